// ===== sv/bdm_pkg.sv =====
// Shared types and constants of the battery discharge monitor.
package bdm_pkg;

    // Configuration port geometry.
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_LEVEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_MID      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_HIGH     = 3'd5;

    // Register values after reset.
    localparam logic [15:0] RST_CUTOFF_LEVEL  = 16'd300;
    localparam logic [7:0]  RST_CUTOFF_COUNT  = 8'd80;
    localparam logic [9:0]  RST_DIVIDER_SCALE = 10'd490;
    localparam logic [9:0]  RST_RATE_LOW      = 10'd100;
    localparam logic [9:0]  RST_RATE_MID      = 10'd250;
    localparam logic [9:0]  RST_RATE_HIGH     = 10'd1000;

    // Request mode codes.
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_SELECT  = 2'd1;
    localparam logic [1:0] MODE_CONFIRM = 2'd2;

    // Current setting codes.
    localparam logic [1:0] SET_LOW  = 2'd0;
    localparam logic [1:0] SET_MID  = 2'd1;
    localparam logic [1:0] SET_HIGH = 2'd2;

    // Arithmetic constants.
    localparam int K_PERCENT = 100;
    localparam int K_SIXTY   = 60;
    localparam logic [15:0] LEVEL_MAX   = 16'hFFFF;
    localparam logic [7:0]  LOW_CNT_MAX = 8'hFF;

    // Geometry of the time and capacity divider.
    localparam int TIME_DIV_W = 16;
    localparam int TIME_REM_W = 6;

    // Status of a serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== sv/bdm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module bdm_div #(
    parameter int DW = 27,
    parameter int VW = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DW-1:0]       i_dividend,
    input  logic [VW-1:0]       i_divisor,
    output bdm_pkg::t_div_stat  o_stat,
    output logic [DW-1:0]       o_quotient,
    output logic [VW-1:0]       o_remainder
);
    import bdm_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [CW-1:0] r_count;
    logic          r_busy;
    logic          r_done;

    logic [VW:0]   w_trial;
    logic          w_ge;
    logic [VW:0]   w_diff;

    // Trial subtraction of the divisor from the partial remainder.
    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    // Control: load on start, then one step per cycle, DW steps in all.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CW'(DW);
            end else if (r_busy) begin
                r_count <= r_count - 1'b1;
                if (r_count == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out at the top as quotient bits enter below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== sv/battery_discharge_monitor_unit.sv =====
// Top level of the battery discharge monitor: request handling, sequencing and results.
//
// Usage. Requests enter on i_valid/o_ready with i_mode and the two ADC samples;
// each request yields exactly one result on o_valid/i_ready. Configuration
// registers are written through i_cfg_we/i_cfg_index/i_cfg_data while idle.
// A select or confirm request, or a tick while the timer is stopped, goes from
// idle straight to the finish state, whose result then enters the output
// register. A tick while the timer runs first passes an arithmetic phase: the
// voltage path runs two serial divisions of SAMPLE_BITS+17 bits each, one bit
// per cycle, with a registered multiply between them. The time and capacity path
// runs three 16-bit serial divisions by 60 on a second divider in parallel.
// One request is in work at a time; the next one is accepted as soon as the
// previous result sits in the output register, even if it is not yet taken.
// When the receiver stalls, a finished result waits in the sequencer until the
// output register frees, and o_ready stays low meanwhile.
// Synchronous active-low reset clears the control and tester state, restores the register
// defaults and empties the output register.
module battery_discharge_monitor_unit #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request channel.
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_mode,
    input  logic [SAMPLE_BITS-1:0]          i_battery_sample,
    input  logic [SAMPLE_BITS-1:0]          i_reference_sample,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [bdm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bdm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Result channel.
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_discharge_drive,
    output logic                            o_charge_drive,
    output logic                            o_timer_running,
    output logic [1:0]                      o_current_setting,
    output logic [4:0]                      o_elapsed_hours,
    output logic [5:0]                      o_elapsed_minutes,
    output logic [5:0]                      o_elapsed_seconds,
    output logic                            o_point_blink,
    output logic [15:0]                     o_battery_level,
    output logic [7:0]                      o_low_ticks,
    output logic [9:0]                      o_capacity_mah,
    output logic                            o_capacity_valid
);
    import bdm_pkg::*;

    localparam int QW   = SAMPLE_BITS + 7;
    localparam int VD_W = SAMPLE_BITS + 17;
    localparam int VR_W = SAMPLE_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WORK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [1:0] VP_Q   = 2'd0;
    localparam logic [1:0] VP_MUL = 2'd1;
    localparam logic [1:0] VP_V   = 2'd2;
    localparam logic [1:0] VP_END = 2'd3;

    localparam logic [1:0] TP_CAP = 2'd0;
    localparam logic [1:0] TP_SEC = 2'd1;
    localparam logic [1:0] TP_MIN = 2'd2;
    localparam logic [1:0] TP_END = 2'd3;

    // Configuration registers.
    logic [15:0] r_cut_level;
    logic [7:0]  r_cut_count;
    logic [9:0]  r_scale;
    logic [9:0]  r_rate_low;
    logic [9:0]  r_rate_mid;
    logic [9:0]  r_rate_high;

    // Tester state.
    logic [15:0] r_sc;
    logic [5:0]  r_lat_min;
    logic [4:0]  r_lat_hr;
    logic [5:0]  r_lat_sec;
    logic [7:0]  r_low_cnt;
    logic [1:0]  r_setting;
    logic        r_charging;
    logic        r_charge;
    logic        r_discharge;
    logic        r_timer;
    logic        r_second;
    logic        r_point;
    logic [9:0]  r_capacity;

    // Sequencer.
    logic [1:0]      r_state;
    logic            r_is_tick;
    logic            r_ref_zero;
    logic [1:0]      r_vph;
    logic [1:0]      r_tph;
    logic [VD_W-1:0] r_vprod;
    logic [15:0]     r_vlevel;
    logic [9:0]      r_cap_q;
    logic [5:0]      r_sec_new;
    logic [4:0]      r_hr_new;
    logic [5:0]      r_min_new;

    // Output register.
    logic        r_out_valid;
    logic        r_out_discharge;
    logic        r_out_charge;
    logic        r_out_timer;
    logic [1:0]  r_out_setting;
    logic [4:0]  r_out_hr;
    logic [5:0]  r_out_min;
    logic [5:0]  r_out_sec;
    logic        r_out_point;
    logic [15:0] r_out_level;
    logic [7:0]  r_out_low_cnt;
    logic [9:0]  r_out_capacity;
    logic        r_out_cap_valid;

    // Dividers.
    t_div_stat             v_stat;
    t_div_stat             t_stat;
    logic                  v_start;
    logic [VD_W-1:0]       v_dividend;
    logic [VR_W-1:0]       v_divisor;
    logic [VD_W-1:0]       v_quo;
    logic [VR_W-1:0]       v_rem;
    logic                  t_start;
    logic [TIME_DIV_W-1:0] t_dividend;
    logic [TIME_DIV_W-1:0] t_quo;
    logic [TIME_REM_W-1:0] t_rem;

    // Combinational helpers.
    logic        w_accept;
    logic        w_out_free;
    logic        w_start_tick;
    logic [9:0]  w_rate;
    logic [15:0] w_cap_prod;
    logic [15:0] w_vsat;
    logic        w_low;

    // Final values of a request.
    logic [15:0] n_level;
    logic        n_stop;
    logic [7:0]  n_low_cnt;
    logic        n_discharge;
    logic        n_timer;
    logic        n_charge;
    logic        n_second;
    logic [9:0]  n_capacity;
    logic        n_upd;
    logic [4:0]  n_lat_hr;
    logic [5:0]  n_lat_min;
    logic [5:0]  n_lat_sec;
    logic        n_point;

    assign o_ready      = (r_state == ST_IDLE);
    assign w_accept     = i_valid && o_ready;
    assign w_out_free   = !r_out_valid || i_ready;
    assign w_start_tick = w_accept && (i_mode == MODE_TICK) && r_timer;

    // Discharge rate of the current setting; the unused code gives zero.
    always_comb begin
        case (r_setting)
            SET_LOW:  w_rate = r_rate_low;
            SET_MID:  w_rate = r_rate_mid;
            SET_HIGH: w_rate = r_rate_high;
            default:  w_rate = '0;
        endcase
    end

    assign w_cap_prod = 16'(w_rate) * 16'(r_lat_min);

    // Saturate the scaled voltage to 16 bits.
    assign w_vsat = (|v_quo[VD_W-1:16]) ? LEVEL_MAX : v_quo[15:0];

    // Start requests and operands of the two dividers.
    always_comb begin
        v_start    = 1'b0;
        v_dividend = VD_W'(i_battery_sample) * VD_W'(K_PERCENT);
        v_divisor  = i_reference_sample;
        t_start    = 1'b0;
        t_dividend = w_cap_prod;
        if (w_start_tick) begin
            v_start = 1'b1;
            t_start = 1'b1;
        end else if (r_state == ST_WORK) begin
            if (r_vph == VP_MUL) begin
                v_start    = 1'b1;
                v_dividend = r_vprod;
                v_divisor  = VR_W'(K_PERCENT);
            end
            if (t_stat.done && (r_tph == TP_CAP)) begin
                t_start    = 1'b1;
                t_dividend = r_sc;
            end else if (t_stat.done && (r_tph == TP_SEC)) begin
                t_start    = 1'b1;
                t_dividend = t_quo;
            end
        end
    end

    bdm_div #(
        .DW (VD_W),
        .VW (VR_W)
    ) u_vdiv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (v_start),
        .i_dividend  (v_dividend),
        .i_divisor   (v_divisor),
        .o_stat      (v_stat),
        .o_quotient  (v_quo),
        .o_remainder (v_rem)
    );

    bdm_div #(
        .DW (TIME_DIV_W),
        .VW (TIME_REM_W)
    ) u_tdiv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (t_start),
        .i_dividend  (t_dividend),
        .i_divisor   (TIME_REM_W'(K_SIXTY)),
        .o_stat      (t_stat),
        .o_quotient  (t_quo),
        .o_remainder (t_rem)
    );

    // Final state and result values of the request in work.
    always_comb begin
        n_level     = r_is_tick ? r_vlevel : '0;
        w_low       = (n_level < r_cut_level);
        n_stop      = r_is_tick && w_low && (r_low_cnt >= r_cut_count);
        n_low_cnt   = r_low_cnt;
        if (r_is_tick) begin
            if (w_low) begin
                if (r_low_cnt != LOW_CNT_MAX) begin
                    n_low_cnt = r_low_cnt + 1'b1;
                end
            end else if (r_low_cnt != '0) begin
                n_low_cnt = r_low_cnt - 1'b1;
            end
        end
        n_discharge = n_stop ? 1'b0 : r_discharge;
        n_timer     = n_stop ? 1'b0 : r_timer;
        n_charge    = n_stop ? 1'b1 : r_charge;
        n_second    = r_second || n_stop;
        n_capacity  = n_stop ? r_cap_q : r_capacity;
        n_upd       = r_is_tick && !n_second;
        n_lat_hr    = n_upd ? r_hr_new  : r_lat_hr;
        n_lat_min   = n_upd ? r_min_new : r_lat_min;
        n_lat_sec   = n_upd ? r_sec_new : r_lat_sec;
        n_point     = n_upd ? !r_point  : r_point;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_level <= RST_CUTOFF_LEVEL;
            r_cut_count <= RST_CUTOFF_COUNT;
            r_scale     <= RST_DIVIDER_SCALE;
            r_rate_low  <= RST_RATE_LOW;
            r_rate_mid  <= RST_RATE_MID;
            r_rate_high <= RST_RATE_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CUTOFF_LEVEL:  r_cut_level <= i_cfg_data;
                REG_CUTOFF_COUNT:  r_cut_count <= i_cfg_data[7:0];
                REG_DIVIDER_SCALE: r_scale     <= i_cfg_data[9:0];
                REG_RATE_LOW:      r_rate_low  <= i_cfg_data[9:0];
                REG_RATE_MID:      r_rate_mid  <= i_cfg_data[9:0];
                REG_RATE_HIGH:     r_rate_high <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer and tester state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_is_tick   <= 1'b0;
            r_ref_zero  <= 1'b0;
            r_vph       <= VP_END;
            r_tph       <= TP_END;
            r_sc        <= '0;
            r_lat_min   <= '0;
            r_lat_hr    <= '0;
            r_lat_sec   <= '0;
            r_low_cnt   <= '0;
            r_setting   <= SET_LOW;
            r_charging  <= 1'b0;
            r_charge    <= 1'b0;
            r_discharge <= 1'b0;
            r_timer     <= 1'b0;
            r_second    <= 1'b0;
            r_point     <= 1'b0;
            r_capacity  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_is_tick <= 1'b0;
                        r_state   <= ST_FIN;
                        case (i_mode)
                            MODE_SELECT: begin
                                r_setting <= (r_setting >= SET_HIGH) ? SET_LOW
                                                                     : r_setting + 1'b1;
                            end
                            MODE_CONFIRM: begin
                                if (r_charging) begin
                                    r_charging <= 1'b0;
                                    r_charge   <= 1'b0;
                                    if (!r_second) begin
                                        r_discharge <= 1'b1;
                                        r_timer     <= 1'b1;
                                    end
                                end else begin
                                    r_charge   <= 1'b1;
                                    r_charging <= 1'b1;
                                end
                            end
                            MODE_TICK: begin
                                if (r_timer) begin
                                    r_is_tick  <= 1'b1;
                                    r_sc       <= r_sc + 1'b1;
                                    r_ref_zero <= (i_reference_sample == '0);
                                    r_vph      <= VP_Q;
                                    r_tph      <= TP_CAP;
                                    r_state    <= ST_WORK;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_WORK: begin
                    // Voltage path: ratio, scale multiply, divide by 100.
                    case (r_vph)
                        VP_Q: begin
                            if (v_stat.done) begin
                                r_vprod <= VD_W'(v_quo[QW-1:0]) * VD_W'(r_scale);
                                r_vph   <= VP_MUL;
                            end
                        end
                        VP_MUL: r_vph <= VP_V;
                        VP_V: begin
                            if (v_stat.done) begin
                                r_vlevel <= r_ref_zero ? LEVEL_MAX : w_vsat;
                                r_vph    <= VP_END;
                            end
                        end
                        default: begin
                        end
                    endcase
                    // Time path: capacity, then seconds, then hours and minutes.
                    case (r_tph)
                        TP_CAP: begin
                            if (t_stat.done) begin
                                r_cap_q <= t_quo[9:0];
                                r_tph   <= TP_SEC;
                            end
                        end
                        TP_SEC: begin
                            if (t_stat.done) begin
                                r_sec_new <= t_rem;
                                r_tph     <= TP_MIN;
                            end
                        end
                        TP_MIN: begin
                            if (t_stat.done) begin
                                r_hr_new  <= t_quo[4:0];
                                r_min_new <= t_rem;
                                r_tph     <= TP_END;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if ((r_vph == VP_END) && (r_tph == TP_END)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_low_cnt   <= n_low_cnt;
                        r_discharge <= n_discharge;
                        r_timer     <= n_timer;
                        r_charge    <= n_charge;
                        r_second    <= n_second;
                        r_capacity  <= n_capacity;
                        r_lat_hr    <= n_lat_hr;
                        r_lat_min   <= n_lat_min;
                        r_lat_sec   <= n_lat_sec;
                        r_point     <= n_point;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Output register: loads a finished result, empties when it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && w_out_free) begin
            r_out_discharge <= n_discharge;
            r_out_charge    <= n_charge;
            r_out_timer     <= n_timer;
            r_out_setting   <= r_setting;
            r_out_hr        <= n_lat_hr;
            r_out_min       <= n_lat_min;
            r_out_sec       <= n_lat_sec;
            r_out_point     <= n_point;
            r_out_level     <= n_level;
            r_out_low_cnt   <= n_low_cnt;
            r_out_capacity  <= n_capacity;
            r_out_cap_valid <= n_stop;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_discharge_drive = r_out_discharge;
    assign o_charge_drive    = r_out_charge;
    assign o_timer_running   = r_out_timer;
    assign o_current_setting = r_out_setting;
    assign o_elapsed_hours   = r_out_hr;
    assign o_elapsed_minutes = r_out_min;
    assign o_elapsed_seconds = r_out_sec;
    assign o_point_blink     = r_out_point;
    assign o_battery_level   = r_out_level;
    assign o_low_ticks       = r_out_low_cnt;
    assign o_capacity_mah    = r_out_capacity;
    assign o_capacity_valid  = r_out_cap_valid;

    // The load and the timer are always switched together.
    a_drive_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discharge == r_timer)
        else $error("discharge drive and timer disagree");

    // Only a running timer can put a tick into the arithmetic phase.
    a_work_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WORK) |-> r_timer)
        else $error("arithmetic phase without running timer");

    // Both dividers have finished before a result is released.
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> (!v_stat.busy && !t_stat.busy))
        else $error("result released while a divider is busy");

    // A reported capacity comes with the load off and the charger on.
    a_cap_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cap_valid) |-> (!r_out_discharge && r_out_charge))
        else $error("capacity reported with inconsistent drives");

endmodule
